[rtl/interval_range_map_core_macros.svh]
// Assertion macros used by the interval range map RTL.
`ifndef INTERVAL_RANGE_MAP_CORE_MACROS_SVH
`define INTERVAL_RANGE_MAP_CORE_MACROS_SVH
// Assert that a condition implies another in the same cycle.
`define IRM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Assert that a condition implies another in the next cycle.
`define IRM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

[rtl/irm_pkg.sv]
// Shared types and constants of the interval range map.
package irm_pkg;
	localparam int MaxBreaksDef = 64;
	localparam int KeyBitsDef = 32;
	localparam int ValBits = 8;
	localparam int CountBits = 7;
	localparam int StatBits = 2;

	typedef enum logic [StatBits-1:0] {
		ST_DONE = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	localparam logic MODE_ASSIGN = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;
endpackage

[rtl/irm_if.sv]
// Valid/ready channel interfaces of the interval range map.
interface irm_in_if #(parameter int KEY_BITS = 32);
	logic valid;
	logic ready;
	logic mode;
	logic signed [KEY_BITS-1:0] range_start;
	logic signed [KEY_BITS-1:0] range_stop;
	logic [7:0] fill_value;
	logic signed [KEY_BITS-1:0] query_key;
	modport source (output valid, mode, range_start, range_stop, fill_value, query_key,
		input ready);
	modport sink (input valid, mode, range_start, range_stop, fill_value, query_key,
		output ready);
endinterface

interface irm_out_if;
	logic valid;
	logic ready;
	logic [7:0] read_value;
	logic [1:0] status;
	logic [6:0] entry_count;
	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

interface irm_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/irm_mem.sv]
// Breakpoint table memory: one write port, one registered read port.
module irm_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/irm_ctrl.sv]
// Sequencer: lookup and assign by read-modify-write passes over the table.
module irm_ctrl
	import irm_pkg::*;
#(
	parameter int MAX_BREAKS = 64,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	irm_in_if.sink  in_ch,
	irm_out_if.source out_ch,
	irm_cfg_if.sink cfg_ch
);
	`include "interval_range_map_core_macros.svh"

	localparam int AW = $clog2(MAX_BREAKS);
	localparam int NW = $clog2(MAX_BREAKS + 3) + 1;
	localparam int EW = KEY_BITS + ValBits;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_COPY, S_DONE} state_t;

	state_t state_q;
	logic [ValBits-1:0] default_q;
	logic [NW-1:0] used_q;
	logic [NW-1:0] idx_q;      // read index of the scan
	logic [NW-1:0] n_q;        // entries in the new table
	logic [NW-1:0] tail_q;     // first entry above stop
	logic mode_q;
	logic signed [KEY_BITS-1:0] b_q, e_q;
	logic [ValBits-1:0] v_q, before_q, after_q, rv_q;
	logic [1:0] ins_q;         // pending inserts: bit0 begin, bit1 stop
	logic [NW-1:0] tail_n_q;
	logic rd_pend_s1;
	logic [NW-1:0] rd_idx_s1;
	logic [1:0] stat_q;
	logic [NW-1:0] cnt_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	// second memory copy holds the old table while the new one is written
	logic [EW-1:0] sdata;
	logic swe;
	logic [AW-1:0] sraddr;

	irm_mem #(.DEPTH(MAX_BREAKS), .WIDTH(EW)) u_main (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));
	irm_mem #(.DEPTH(MAX_BREAKS), .WIDTH(EW)) u_shadow (
		.clk(clk), .we(swe), .waddr(waddr), .wdata(wdata), .raddr(sraddr), .rdata(sdata));

	logic signed [KEY_BITS-1:0] rkey;
	logic [ValBits-1:0] rval;
	assign rkey = rdata[EW-1:ValBits];
	assign rval = rdata[ValBits-1:0];

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = (state_q == S_DONE);
	assign out_ch.read_value = rv_q;
	assign out_ch.status = stat_q;
	assign out_ch.entry_count = cnt_q[CountBits-1:0];

	// Phase plan for an assign: S_SCAN reads the old table from main and mirrors
	// it into shadow (swe at the read address), gathering before/after and tail.
	// S_WRITE then writes the inserts after the prefix kept in place; S_COPY copies the tail from shadow.
	logic scan_last;
	assign scan_last = (idx_q >= used_q);

	always_comb begin
		raddr = idx_q[AW-1:0];
		sraddr = idx_q[AW-1:0];
		we = 1'b0;
		swe = 1'b0;
		waddr = rd_idx_s1[AW-1:0];
		wdata = rdata;
		if (state_q == S_SCAN && rd_pend_s1 && mode_q == MODE_ASSIGN) begin
			swe = 1'b1;
		end
		// hold the table when the assign is rejected
		if (state_q == S_WRITE && tail_n_q <= NW'(MAX_BREAKS)) begin
			waddr = n_q[AW-1:0];
			if (ins_q[0]) begin
				we = 1'b1;
				wdata = {b_q, v_q};
			end else if (ins_q[1]) begin
				we = 1'b1;
				wdata = {e_q, after_q};
			end
		end
		if (state_q == S_COPY && rd_pend_s1) begin
			we = 1'b1;
			waddr = n_q[AW-1:0];
			wdata = sdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			default_q <= '0;
			used_q <= '0;
			idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			n_q <= '0;
			tail_q <= '0;
			tail_n_q <= '0;
			ins_q <= '0;
			mode_q <= 1'b0;
			b_q <= '0;
			e_q <= '0;
			v_q <= '0;
			before_q <= '0;
			after_q <= '0;
			rv_q <= '0;
			stat_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_ch.valid) begin
				default_q <= cfg_ch.data;
			end
			rd_pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						mode_q <= in_ch.mode;
						b_q <= in_ch.range_start;
						e_q <= in_ch.range_stop;
						v_q <= in_ch.fill_value;
						idx_q <= '0;
						n_q <= '0;
						tail_q <= used_q;
						before_q <= default_q;
						after_q <= default_q;
						rv_q <= default_q;
						if (in_ch.mode == MODE_LOOKUP) begin
							e_q <= in_ch.query_key;
							state_q <= S_SCAN;
						end else if (in_ch.range_start >= in_ch.range_stop) begin
							rv_q <= '0;
							stat_q <= ST_EMPTY;
							cnt_q <= used_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!scan_last) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1 <= idx_q;
						idx_q <= idx_q + 1'b1;
					end
					if (rd_pend_s1) begin
						// value at e: last key <= e
						if (rkey <= e_q) begin
							after_q <= rval;
							rv_q <= rval;
						end
						if (rkey < b_q) begin
							before_q <= rval;
							n_q <= rd_idx_s1 + 1'b1;
						end
						if (rkey > e_q && tail_q == used_q) begin
							tail_q <= rd_idx_s1;
						end
					end
					if (scan_last && !rd_pend_s1) begin
						if (mode_q == MODE_LOOKUP) begin
							stat_q <= ST_DONE;
							cnt_q <= used_q;
							state_q <= S_DONE;
						end else begin
							ins_q <= {after_q != v_q, before_q != v_q};
							tail_n_q <= n_q + NW'(before_q != v_q) + NW'(after_q != v_q)
								+ (used_q - tail_q);
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					if (tail_n_q > NW'(MAX_BREAKS)) begin
						rv_q <= '0;
						stat_q <= ST_FULL;
						cnt_q <= used_q;
						state_q <= S_DONE;
					end else if (ins_q[0]) begin
						ins_q[0] <= 1'b0;
						n_q <= n_q + 1'b1;
					end else if (ins_q[1]) begin
						ins_q[1] <= 1'b0;
						n_q <= n_q + 1'b1;
					end else begin
						idx_q <= tail_q;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					if (idx_q < used_q) begin
						rd_pend_s1 <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
					if (rd_pend_s1) begin
						n_q <= n_q + 1'b1;
					end
					if (idx_q >= used_q && !rd_pend_s1) begin
						used_q <= n_q;
						rv_q <= '0;
						stat_q <= ST_DONE;
						cnt_q <= n_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IRM_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, used_q <= NW'(MAX_BREAKS),
		"table count above capacity")
	`IRM_ASSERT_IMP(a_full_keeps, clk, arst_n, out_ch.valid && stat_q == ST_FULL,
		cnt_q == used_q, "rejected assign changed the count")
	`IRM_ASSERT_NEXT(a_hold_out, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(rv_q) && $stable(stat_q), "result dropped while stalled")
	`IRM_ASSERT_IMP(a_no_write_idle, clk, arst_n, in_ch.ready, !we && !swe,
		"table written while idle")
endmodule

[rtl/interval_range_map_core.sv]
// Top level of the interval range map.
// Each transaction takes one result. A lookup scans the table through the
// registered memory read port. An assign scans the table once (mirroring it
// into a shadow memory), writes up to two new breakpoints, then copies the
// entries above the range back from the shadow. Empty ranges finish without
// a scan. The result waits in an output register until taken.
module interval_range_map_core
	import irm_pkg::*;
#(
	parameter int MAX_BREAKS = MaxBreaksDef,
	parameter int KEY_BITS = KeyBitsDef
) (
	input logic clk,
	input logic arst_n,
	irm_in_if.sink  in_ch,
	irm_out_if.source out_ch,
	irm_cfg_if.sink cfg_ch
);
	irm_ctrl #(.MAX_BREAKS(MAX_BREAKS), .KEY_BITS(KEY_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));
endmodule
